[rtl/bbme_pkg.sv]
// ============================================================================
// bbme_pkg
// Shared widths, reset values, register indexes and handshake structs of the
// byte block modular exponentiation core.
// ============================================================================
package bbme_pkg;

    localparam int WORD_W              = 64;
    localparam int BYTE_W              = 8;
    localparam int CFG_IDX_W           = 2;
    localparam int BB_W                = 4;
    localparam int MAX_BLOCK_BYTES_DEF = 8;

    typedef logic [WORD_W-1:0] word_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODULUS     = 2'd0,
        CFG_EXPONENT    = 2'd1,
        CFG_BLOCK_BYTES = 2'd2
    } cfg_idx_t;

    localparam word_t           MODULUS_RST     = 64'd2;
    localparam word_t           EXPONENT_RST    = 64'd1;
    localparam logic [BB_W-1:0] BLOCK_BYTES_RST = 4'd8;

    // Request into the shared modular multiplier: start pulse with operands.
    typedef struct packed {
        logic  start;
        word_t x;
        word_t y;
    } mm_req_t;

    // Response of the multiplier: done pulse with x * y mod n.
    typedef struct packed {
        logic  done;
        word_t prod;
    } mm_rsp_t;

    // Status of the exponent sequencer toward the top level.
    typedef struct packed {
        logic  busy;
        logic  done;
        word_t value;
    } seq_stat_t;

endpackage

[rtl/bbme_mulmod.sv]
// ============================================================================
// bbme_mulmod
// Iterative modular multiplier: x * y mod n by shift-and-add, one bit of y
// per clock, most significant bit first. Operands must be below n.
// ============================================================================
module bbme_mulmod (
    input  logic              aclk,
    input  logic              aresetn,
    input  bbme_pkg::word_t   modulus,
    input  bbme_pkg::mm_req_t req,
    output bbme_pkg::mm_rsp_t rsp
);

    localparam int W     = bbme_pkg::WORD_W;
    localparam int CNT_W = $clog2(W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [W-1:0]     x_reg;
    logic [W-1:0]     y_reg;
    logic [W-1:0]     acc_reg;
    logic [W-1:0]     prod_reg;

    logic [W-1:0]     addend;
    logic [W+1:0]     sum;
    logic [W+1:0]     mod_1x;
    logic [W+1:0]     mod_2x;
    logic [W+1:0]     reduced;
    logic [W-1:0]     acc_next;
    logic             last_bit;

    // 2*acc + addend stays below 3n, so at most two subtractions of n
    always_comb begin
        addend  = y_reg[W-1] ? x_reg : '0;
        sum     = {1'b0, acc_reg, 1'b0} + {2'b00, addend};
        mod_1x  = {2'b00, modulus};
        mod_2x  = {1'b0, modulus, 1'b0};
        if (sum >= mod_2x) begin
            reduced = sum - mod_2x;
        end else if (sum >= mod_1x) begin
            reduced = sum - mod_1x;
        end else begin
            reduced = sum;
        end
        acc_next = reduced[W-1:0];
        last_bit = (cnt_reg == CNT_W'(W - 1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                x_reg    <= req.x;
                y_reg    <= req.y;
                acc_reg  <= '0;
            end else if (busy_reg) begin
                acc_reg <= acc_next;
                y_reg   <= {y_reg[W-2:0], 1'b0};
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (last_bit) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    prod_reg <= acc_next;
                end
            end
        end
    end

    assign rsp = '{done: done_reg, prod: prod_reg};

endmodule

[rtl/bbme_seq.sv]
// ============================================================================
// bbme_seq
// Exponent sequencer: reduces the block modulo n, then walks the exponent
// right to left, issuing multiplies and squarings to the shared multiplier.
// ============================================================================
module bbme_seq (
    input  logic                aclk,
    input  logic                aresetn,
    input  bbme_pkg::word_t     modulus,
    input  bbme_pkg::word_t     exponent,
    input  logic                start,
    input  bbme_pkg::word_t     base_in,
    input  logic                out_ack,
    output bbme_pkg::seq_stat_t stat,
    output bbme_pkg::mm_req_t   mm_req,
    input  bbme_pkg::mm_rsp_t   mm_rsp
);

    localparam int W = bbme_pkg::WORD_W;
    localparam logic [W-1:0] ONE  = W'(1);
    localparam logic [W-1:0] ZERO = '0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_MUL,
        ST_SQR,
        ST_DONE
    } state_t;

    state_t       state_reg;
    logic [W-1:0] base_reg;
    logic [W-1:0] result_reg;
    logic [W-1:0] power_reg;
    logic         req_start_reg;
    logic [W-1:0] req_x_reg;
    logic [W-1:0] req_y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            req_start_reg <= 1'b0;
        end else begin
            req_start_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (start) begin
                        power_reg <= exponent;
                        if (exponent == ZERO) begin
                            result_reg <= ONE;
                            state_reg  <= ST_DONE;
                        end else if (modulus == ZERO) begin
                            result_reg <= ZERO;
                            state_reg  <= ST_DONE;
                        end else begin
                            // base mod n by Horner over the bits of base, adding 1 mod n
                            result_reg    <= (modulus == ONE) ? ZERO : ONE;
                            req_x_reg     <= (modulus == ONE) ? ZERO : ONE;
                            req_y_reg     <= base_in;
                            req_start_reg <= 1'b1;
                            state_reg     <= ST_REDUCE;
                        end
                    end
                end
                ST_REDUCE: begin
                    if (mm_rsp.done) begin
                        base_reg      <= mm_rsp.prod;
                        req_start_reg <= 1'b1;
                        req_y_reg     <= mm_rsp.prod;
                        if (power_reg[0]) begin
                            req_x_reg <= result_reg;
                            state_reg <= ST_MUL;
                        end else begin
                            req_x_reg <= mm_rsp.prod;
                            state_reg <= ST_SQR;
                        end
                    end
                end
                ST_MUL: begin
                    if (mm_rsp.done) begin
                        result_reg <= mm_rsp.prod;
                        if (power_reg[W-1:1] == ZERO[W-1:1]) begin
                            state_reg <= ST_DONE;
                        end else begin
                            req_x_reg     <= base_reg;
                            req_y_reg     <= base_reg;
                            req_start_reg <= 1'b1;
                            state_reg     <= ST_SQR;
                        end
                    end
                end
                ST_SQR: begin
                    if (mm_rsp.done) begin
                        base_reg  <= mm_rsp.prod;
                        power_reg <= {1'b0, power_reg[W-1:1]};
                        if (power_reg[W-1:1] == ZERO[W-1:1]) begin
                            state_reg <= ST_DONE;
                        end else begin
                            req_start_reg <= 1'b1;
                            req_y_reg     <= mm_rsp.prod;
                            if (power_reg[1]) begin
                                req_x_reg <= result_reg;
                                state_reg <= ST_MUL;
                            end else begin
                                req_x_reg <= mm_rsp.prod;
                                state_reg <= ST_SQR;
                            end
                        end
                    end
                end
                ST_DONE: begin
                    // hold the result until the output register takes it
                    if (out_ack) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign stat = '{busy:  (state_reg != ST_IDLE),
                    done:  (state_reg == ST_DONE),
                    value: result_reg};

    assign mm_req = '{start: req_start_reg, x: req_x_reg, y: req_y_reg};

endmodule

[rtl/byte_block_modular_exponentiation_core.sv]
// ============================================================================
// byte_block_modular_exponentiation_core
// Packs message bytes big-endian into blocks and emits block^e mod n per block.
// ============================================================================
// A byte that does not complete a block is shifted into the accumulator. The
// byte that completes a block (block_bytes reached, or last_byte set) starts an
// exponentiation and s_ready stays low until the result is handed to the
// output register. The time is set by the one shared bit-serial modular
// multiplier. Each block takes one reduction of the block, L - 1 squarings and
// P multiplies, where L is the bit length of the exponent and P its count of
// one bits; the result may then wait on m_ready. A zero exponent or zero
// modulus finishes without using the multiplier.
// Registers: 0 modulus, 1 exponent, 2 block_bytes (0 acts as 1, values above
// MAX_BLOCK_BYTES saturate); other indexes are ignored. Write them only idle.
module byte_block_modular_exponentiation_core #(
    parameter int MAX_BLOCK_BYTES = bbme_pkg::MAX_BLOCK_BYTES_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [bbme_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bbme_pkg::WORD_W-1:0]    cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [bbme_pkg::BYTE_W-1:0]    s_data_byte,
    input  logic                           s_last_byte,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [bbme_pkg::WORD_W-1:0]    m_cipher_block,
    output logic                           m_last_block
);

    localparam int W     = bbme_pkg::WORD_W;
    localparam int BW    = bbme_pkg::BYTE_W;
    localparam int BBW   = bbme_pkg::BB_W;
    localparam int ACC_W = MAX_BLOCK_BYTES * BW;
    localparam int CNT_W = $clog2(MAX_BLOCK_BYTES + 1);

    logic [W-1:0]     modulus_reg;
    logic [W-1:0]     exponent_reg;
    logic [BBW-1:0]   block_bytes_reg;
    logic [ACC_W-1:0] acc_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             last_pend_reg;
    logic             m_valid_reg;
    logic [W-1:0]     cipher_reg;
    logic             last_block_reg;

    logic [ACC_W+BW-1:0] acc_wide;
    logic [ACC_W-1:0]    acc_next;
    logic [BBW-1:0]      limit;
    logic [BBW-1:0]      cnt_plus;
    logic                accept;
    logic                complete;
    logic                out_free;
    logic                out_ack;

    bbme_pkg::seq_stat_t stat;
    bbme_pkg::mm_req_t   mm_req;
    bbme_pkg::mm_rsp_t   mm_rsp;

    always_comb begin
        if (block_bytes_reg == '0) begin
            limit = BBW'(1);
        end else if (block_bytes_reg > BBW'(MAX_BLOCK_BYTES)) begin
            limit = BBW'(MAX_BLOCK_BYTES);
        end else begin
            limit = block_bytes_reg;
        end
        acc_wide = {acc_reg, s_data_byte};
        acc_next = acc_wide[ACC_W-1:0];
        cnt_plus = BBW'(cnt_reg) + BBW'(1);
        complete = (cnt_plus >= limit) || s_last_byte;
        s_ready  = !stat.busy;
        accept   = s_valid && s_ready;
        out_free = !m_valid_reg || m_ready;
        out_ack  = stat.done && out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_reg     <= bbme_pkg::MODULUS_RST;
            exponent_reg    <= bbme_pkg::EXPONENT_RST;
            block_bytes_reg <= bbme_pkg::BLOCK_BYTES_RST;
            acc_reg         <= '0;
            cnt_reg         <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    bbme_pkg::CFG_MODULUS:     modulus_reg     <= cfg_wdata;
                    bbme_pkg::CFG_EXPONENT:    exponent_reg    <= cfg_wdata;
                    bbme_pkg::CFG_BLOCK_BYTES: block_bytes_reg <= cfg_wdata[BBW-1:0];
                    default: begin
                    end
                endcase
            end
            if (accept) begin
                if (complete) begin
                    acc_reg       <= '0;
                    cnt_reg       <= '0;
                    last_pend_reg <= s_last_byte;
                end else begin
                    acc_reg <= acc_next;
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
            end
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (out_ack) begin
                m_valid_reg    <= 1'b1;
                cipher_reg     <= stat.value;
                last_block_reg <= last_pend_reg;
            end
        end
    end

    bbme_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .modulus  (modulus_reg),
        .exponent (exponent_reg),
        .start    (accept && complete),
        .base_in  (W'(acc_next)),
        .out_ack  (out_ack),
        .stat     (stat),
        .mm_req   (mm_req),
        .mm_rsp   (mm_rsp)
    );

    bbme_mulmod u_mulmod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .modulus (modulus_reg),
        .req     (mm_req),
        .rsp     (mm_rsp)
    );

    assign m_valid        = m_valid_reg;
    assign m_cipher_block = cipher_reg;
    assign m_last_block   = last_block_reg;

endmodule
